>>> rtl/mbps_pkg.sv
// Shared types, constants and helper functions of the masked byte pattern search unit.
`default_nettype none
package mbps_pkg;

   localparam int MAX_PATTERN_BYTES_DEF = 16;
   localparam int ADDRESS_BITS_DEF      = 48;

   localparam int BYTE_W   = 8;
   localparam int ADDR_W   = 48;
   localparam int COUNT_W  = 16;
   localparam int LEN_W    = 5;
   localparam int PIDX_W   = 4;
   localparam int CARE_W   = 32;
   localparam int CSR_W    = 64;
   localparam int PADDR_W  = 6;
   localparam int REG_IDX_W = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Register indexes of the configuration port (byte address 8*index).
   typedef enum logic [REG_IDX_W-1:0] {
      REG_PATTERN_LOW  = 3'd0,
      REG_PATTERN_HIGH = 3'd1,
      REG_CARE_MASK    = 3'd2,
      REG_PATTERN_LEN  = 3'd3,
      REG_MATCH_LIMIT  = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [CSR_W-1:0]   pattern_low;
      logic [CSR_W-1:0]   pattern_high;
      logic [CARE_W-1:0]  care_mask;
      logic [LEN_W-1:0]   pattern_length;
      logic [COUNT_W-1:0] match_limit;
   } cfg_type;

   // Pattern byte k, byte 0 in the low bits of the low word.
   function automatic logic [BYTE_W-1:0] pattern_byte(input cfg_type cfg,
                                                      input logic [PIDX_W-1:0] k);
      logic [2*CSR_W-1:0] all_bytes;
      all_bytes = {cfg.pattern_high, cfg.pattern_low};
      return all_bytes[k*BYTE_W +: BYTE_W];
   endfunction

   // Care bits of pattern byte k: bit 0 for the low nibble, bit 1 for the high one.
   function automatic logic [1:0] care_bits(input cfg_type cfg,
                                            input logic [PIDX_W-1:0] k);
      return cfg.care_mask[k*2 +: 2];
   endfunction

endpackage
`default_nettype wire

>>> rtl/mbps_cell.sv
// One window cell: holds one stream byte, passes it on, and compares it with its pattern byte.
`default_nettype none
module mbps_cell
   import mbps_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              shift_en,
   input  wire logic [BYTE_W-1:0] byte_in,
   input  wire logic [BYTE_W-1:0] want_byte,
   input  wire logic [1:0]        care,
   input  wire logic              active,
   output logic      [BYTE_W-1:0] byte_out,
   output logic                   hit
);

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in_mux;
   logic [BYTE_W-1:0] care_full;

   assign byte_in_mux = shift_en ? byte_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_mux;
   end

   // The compare looks at the byte this cell holds after the shift.
   assign care_full = {{4{care[1]}}, {4{care[0]}}};
   assign hit       = !active || (((byte_in ^ want_byte) & care_full) == '0);
   assign byte_out  = byte_ff;

endmodule
`default_nettype wire

>>> rtl/mbps_csr.sv
// Configuration register file with its APB-style access port.
`default_nettype none
module mbps_csr
   import mbps_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [CSR_W-1:0]   pwdata,
   output logic      [CSR_W-1:0]   prdata,
   output logic                    pready,
   output cfg_type                 cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          write_en;

   assign pready   = 1'b1;
   assign reg_sel  = reg_index_type'(paddr[PADDR_W-1 -: REG_IDX_W]);
   assign write_en = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_sel)
            REG_PATTERN_LOW:  cfg_in.pattern_low    = pwdata;
            REG_PATTERN_HIGH: cfg_in.pattern_high   = pwdata;
            REG_CARE_MASK:    cfg_in.care_mask      = pwdata[CARE_W-1:0];
            REG_PATTERN_LEN:  cfg_in.pattern_length = pwdata[LEN_W-1:0];
            REG_MATCH_LIMIT:  cfg_in.match_limit    = pwdata[COUNT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low    <= '0;
         cfg_ff.pattern_high   <= '0;
         cfg_ff.care_mask      <= '0;
         cfg_ff.pattern_length <= LEN_W'(1);
         cfg_ff.match_limit    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_PATTERN_LOW:  prdata = cfg_ff.pattern_low;
         REG_PATTERN_HIGH: prdata = cfg_ff.pattern_high;
         REG_CARE_MASK:    prdata = CSR_W'(cfg_ff.care_mask);
         REG_PATTERN_LEN:  prdata = CSR_W'(cfg_ff.pattern_length);
         REG_MATCH_LIMIT:  prdata = CSR_W'(cfg_ff.match_limit);
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

>>> rtl/masked_byte_pattern_search_unit.sv
// Top level of the masked byte pattern search unit.
// Usage:
//   The request channel (req_valid/req_ready) carries one word per stream byte:
//   the byte, its address and a new-run flag that clears the window and the
//   match count before the byte is taken. Every request word yields exactly one
//   response word on rsp_valid/rsp_ready: found, the match start address (zero
//   when nothing is found), the running match count and the limit flag.
//   The window is a row of MAX_PATTERN_BYTES cells; each accepted byte enters
//   the first cell and every cell passes its byte to the next. All cells compare
//   in parallel, so one byte is taken per cycle while the receiver keeps up,
//   and its response is registered in the cycle after acceptance.
//   A new byte is taken whenever the response register is empty or being
//   drained in the same cycle; if the receiver stalls, the response holds and
//   req_ready stays low until it is taken, so at most one word waits inside.
//   Reset clears the window fill, count, stop flag and response valid, and
//   loads the reset values of the registers (pattern length one).
//   Registers sit at byte address 8*index on the APB-style port and may be
//   written only while no word is in flight.
`default_nettype none
module masked_byte_pattern_search_unit
   import mbps_pkg::*;
#(
   parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
   parameter int ADDRESS_BITS      = ADDRESS_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [BYTE_W-1:0]  req_data_byte,
   input  wire logic [ADDR_W-1:0]  req_byte_address,
   input  wire logic               req_new_run,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_found,
   output logic      [ADDR_W-1:0]  rsp_found_address,
   output logic      [COUNT_W-1:0] rsp_matches_so_far,
   output logic                    rsp_limit_reached,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [CSR_W-1:0]   pwdata,
   output logic      [CSR_W-1:0]   prdata,
   output logic                    pready
);

   localparam int FILL_W    = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int KEEP_BITS = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
   localparam logic [ADDR_W-1:0] ADDR_KEEP = {ADDR_W{1'b1}} >> (ADDR_W - KEEP_BITS);
   localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_PATTERN_BYTES);
   localparam logic [FILL_W-1:0] MAX_FILL  = FILL_W'(MAX_PATTERN_BYTES);

   cfg_type cfg;

   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic               stopped_ff, stopped_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               found_ff, found_in;
   logic [ADDR_W-1:0]  address_ff, address_in;

   logic                          accept;
   logic [LEN_W-1:0]              eff_len;
   logic [BYTE_W-1:0]             cell_byte [MAX_PATTERN_BYTES];
   logic [MAX_PATTERN_BYTES-1:0]  cell_hit;
   logic [FILL_W-1:0]             fill_base;
   logic [FILL_W-1:0]             fill_next;
   logic [COUNT_W-1:0]            total_base;
   logic                          stopped_base;
   logic                          candidate;
   logic                          limit_on;

   mbps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (cfg.pattern_length == '0) begin
         eff_len = LEN_W'(1);
      end else if (cfg.pattern_length > MAX_LEN) begin
         eff_len = MAX_LEN;
      end else begin
         eff_len = cfg.pattern_length;
      end
   end

   // Cell i holds the byte of age i; it is compared with pattern byte len-1-i.
   for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
      logic [BYTE_W-1:0] cell_in;
      logic [PIDX_W-1:0] pidx;
      logic              cell_active;

      if (i == 0) begin : g_first
         assign cell_in = req_data_byte;
      end else begin : g_rest
         assign cell_in = req_new_run ? '0 : cell_byte[i-1];
      end

      assign cell_active = LEN_W'(i) < eff_len;
      assign pidx        = PIDX_W'(eff_len - LEN_W'(i + 1));

      mbps_cell u_cell (
         .clock     (clock),
         .shift_en  (accept),
         .byte_in   (cell_in),
         .want_byte (pattern_byte(cfg, pidx)),
         .care      (care_bits(cfg, pidx)),
         .active    (cell_active),
         .byte_out  (cell_byte[i]),
         .hit       (cell_hit[i])
      );
   end

   assign fill_base    = req_new_run ? '0 : fill_ff;
   assign total_base   = req_new_run ? '0 : total_ff;
   assign stopped_base = req_new_run ? 1'b0 : stopped_ff;
   assign fill_next    = (fill_base < MAX_FILL) ? fill_base + FILL_W'(1) : fill_base;
   assign limit_on     = cfg.match_limit != '0;
   assign candidate    = (LEN_W'(fill_next) >= eff_len) && !stopped_base && (&cell_hit);

   always_comb begin
      total_in     = total_base;
      stopped_in   = stopped_base;
      found_in     = 1'b0;
      address_in   = '0;
      if (candidate) begin
         if (limit_on && (total_base >= cfg.match_limit)) begin
            // The limit was lowered during the run: stop without reporting.
            stopped_in = 1'b1;
         end else begin
            found_in   = 1'b1;
            address_in = (req_byte_address - ADDR_W'(eff_len - LEN_W'(1))) & ADDR_KEEP;
            if (total_base != COUNT_MAX) begin
               total_in = total_base + COUNT_W'(1);
            end
            stopped_in = limit_on && (total_in >= cfg.match_limit);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         total_ff     <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            fill_ff    <= fill_next;
            total_ff   <= total_in;
            stopped_ff <= stopped_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         found_ff   <= found_in;
         address_ff <= address_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = found_ff;
   assign rsp_found_address  = address_ff;
   assign rsp_matches_so_far = total_ff;
   assign rsp_limit_reached  = stopped_ff;

   // A reported match always leaves a nonzero count behind it.
   a_found_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_matches_so_far != '0)
      else $error("match reported with zero count");

   // A word that starts a new run leaves exactly one byte in the window.
   a_new_run_fill: assert property (@(posedge clock) disable iff (reset)
      accept && req_new_run |=> fill_ff == FILL_W'(1))
      else $error("window fill not restarted by new run");

   // Within a run the match count never goes down.
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      accept && !req_new_run |=> total_ff >= $past(total_ff))
      else $error("match count decreased within a run");

   // A word without a match carries a zero start address.
   a_no_match_address: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_found_address == '0)
      else $error("start address set without a match");

endmodule
`default_nettype wire
